[src/b64e_pkg.sv]
// ----------------------------------------------------------------------------
// b64e_pkg: shared types and constants of the base64 stream encoder
// Holds the op codes, group phase codes, queue entry type and the alphabet.
// ----------------------------------------------------------------------------
package b64e_pkg;

  localparam logic       OP_DATA  = 1'b0;
  localparam logic       OP_FLUSH = 1'b1;

  localparam logic [1:0] PH_0 = 2'd0;
  localparam logic [1:0] PH_1 = 2'd1;
  localparam logic [1:0] PH_2 = 2'd2;

  localparam logic [6:0] PAD_CHAR = 7'h3D;

  localparam int QUEUE_DEPTH = 2;

  // One queued job: up to three characters, index of the final one, flush flag
  typedef struct packed {
    logic [6:0] c0;
    logic [6:0] c1;
    logic [6:0] c2;
    logic [1:0] last_idx;
    logic       flush;
  } job_t;

  // Map a 6-bit value to its base64 ASCII character
  function automatic logic [6:0] sym(input logic [5:0] six);
    logic [6:0] v;
    v = {1'b0, six};
    if (six < 6'd26) begin
      sym = 7'd65 + v;
    end else if (six < 6'd52) begin
      sym = 7'd71 + v;           // 'a' - 26
    end else if (six < 6'd62) begin
      sym = v - 7'd4;            // '0' - 52
    end else if (six == 6'd62) begin
      sym = 7'h2B;
    end else begin
      sym = 7'h2F;
    end
  endfunction

endpackage

[src/b64e_if.sv]
// ----------------------------------------------------------------------------
// b64e_in_if / b64e_out_if: valid/ready channels of the encoder
// Input carries op and data_byte; output carries one character per transfer.
// ----------------------------------------------------------------------------
interface b64e_in_if;
  logic       valid;
  logic       ready;
  logic       op;
  logic [7:0] data_byte;

  modport source (output valid, output op, output data_byte, input ready);
  modport sink   (input valid, input op, input data_byte, output ready);
endinterface

interface b64e_out_if;
  logic       valid;
  logic       ready;
  logic [6:0] out_char;
  logic       last_of_run;
  logic       flush_char;

  modport source (output valid, output out_char, output last_of_run,
                  output flush_char, input ready);
  modport sink   (input valid, input out_char, input last_of_run,
                  input flush_char, output ready);
endinterface

[src/base64_stream_encoder_top.sv]
// ----------------------------------------------------------------------------
// base64_stream_encoder_top: streaming base64 encoder with '=' padding
// Takes message bytes and end-of-message items, emits ASCII characters.
// ----------------------------------------------------------------------------
// Usage:
//   in_s  : op = 0 carries a message byte in data_byte, op = 1 ends the
//           message and flushes leftover bits plus '=' pads.
//   out_m : one ASCII character per transfer. last_of_run marks the final
//           character caused by one input item, flush_char marks characters
//           of a flush. A flush with nothing left over produces no transfer.
// Path: an item is written into the job queue, and its characters are then
//   loaded one by one from the queue head into the output register.
// Rate: the output register gives one character per cycle while out_m.ready
//   is high and the queue holds a job; most bytes yield 1 character, the
//   third byte of a group 2, a flush up to 3.
//   A two-entry job queue sits between the front (group tracking) and the
//   back (emitter); in_s.ready is low only while that queue is full.
// Reset: synchronous, active low; clears group phase, previous byte, the
//   queue and the output valid.
// Stall: when out_m.ready is low the output holds; the front keeps taking
//   items until the queue fills, then drops in_s.ready.
// ----------------------------------------------------------------------------
module base64_stream_encoder_top #(
  parameter int QDEPTH = b64e_pkg::QUEUE_DEPTH
) (
  input  logic clk,
  input  logic rst_n,
  b64e_in_if.sink    in_s,
  b64e_out_if.source out_m
);
  import b64e_pkg::*;

  logic take;
  logic push, pop, full, empty;
  job_t new_job, head_job;

  // Accept whenever the queue has a free slot
  assign in_s.ready = !full;
  assign take       = in_s.valid && in_s.ready;

  b64e_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .take      (take),
    .op        (in_s.op),
    .data_byte (in_s.data_byte),
    .push      (push),
    .job       (new_job)
  );

  b64e_queue #(.DEPTH(QDEPTH)) u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (push),
    .wr_job (new_job),
    .pop    (pop),
    .head   (head_job),
    .full   (full),
    .empty  (empty)
  );

  b64e_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .head        (head_job),
    .empty       (empty),
    .pop         (pop),
    .out_valid   (out_m.valid),
    .out_ready   (out_m.ready),
    .out_char    (out_m.out_char),
    .last_of_run (out_m.last_of_run),
    .flush_char  (out_m.flush_char)
  );

endmodule

[src/b64e_front.sv]
// ----------------------------------------------------------------------------
// b64e_front: group tracking and character formation
// Keeps phase and previous byte, turns each item into a queued job.
// ----------------------------------------------------------------------------
module b64e_front (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          take,
  input  logic          op,
  input  logic [7:0]    data_byte,
  output logic          push,
  output b64e_pkg::job_t job
);
  import b64e_pkg::*;

  logic [1:0] phase_r, phase_nxt;
  logic [7:0] prev_r, prev_nxt;
  logic       has_out;

  always_comb begin
    job       = '0;
    has_out   = 1'b1;
    phase_nxt = phase_r;
    prev_nxt  = prev_r;
    if (op == OP_DATA) begin
      prev_nxt = data_byte;
      case (phase_r)
        PH_1: begin
          job.c0    = sym({prev_r[1:0], data_byte[7:4]});
          phase_nxt = PH_2;
        end
        PH_2: begin
          job.c0       = sym({prev_r[3:0], data_byte[7:6]});
          job.c1       = sym(data_byte[5:0]);
          job.last_idx = 2'd1;
          phase_nxt    = PH_0;
        end
        default: begin
          job.c0    = sym(data_byte[7:2]);
          phase_nxt = PH_1;
        end
      endcase
    end else begin
      job.flush = 1'b1;
      phase_nxt = PH_0;
      case (phase_r)
        PH_1: begin
          job.c0       = sym({prev_r[1:0], 4'b0000});
          job.c1       = PAD_CHAR;
          job.c2       = PAD_CHAR;
          job.last_idx = 2'd2;
        end
        PH_2: begin
          job.c0       = sym({prev_r[3:0], 2'b00});
          job.c1       = PAD_CHAR;
          job.last_idx = 2'd1;
        end
        default: begin
          has_out = 1'b0;     // drop: nothing left over
        end
      endcase
    end
  end

  assign push = take && has_out;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_0;
      prev_r  <= 8'd0;
    end else if (take) begin
      phase_r <= phase_nxt;
      prev_r  <= prev_nxt;
    end
  end

endmodule

[src/b64e_queue.sv]
// ----------------------------------------------------------------------------
// b64e_queue: small job queue between front and back
// Register-based FIFO; head entry is visible without a pop.
// ----------------------------------------------------------------------------
module b64e_queue #(
  parameter int DEPTH = b64e_pkg::QUEUE_DEPTH
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  b64e_pkg::job_t wr_job,
  input  logic           pop,
  output b64e_pkg::job_t head,
  output logic           full,
  output logic           empty
);
  import b64e_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  job_t          mem_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CW-1:0] count_r;

  assign full  = (count_r == FULL_CNT);
  assign empty = (count_r == '0);
  assign head  = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wr_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

[src/b64e_back.sv]
// ----------------------------------------------------------------------------
// b64e_back: character emitter
// Loads head job characters into the output register, one per unstalled cycle.
// ----------------------------------------------------------------------------
module b64e_back (
  input  logic           clk,
  input  logic           rst_n,
  input  b64e_pkg::job_t head,
  input  logic           empty,
  output logic           pop,
  output logic           out_valid,
  input  logic           out_ready,
  output logic [6:0]     out_char,
  output logic           last_of_run,
  output logic           flush_char
);
  import b64e_pkg::*;

  logic [1:0] idx_r, idx_nxt;
  logic       valid_r, valid_nxt;
  logic [6:0] char_r;
  logic       last_r, flush_r;
  logic       load, is_last;
  logic [6:0] sel_char;

  assign load    = !empty && (!valid_r || out_ready);
  assign is_last = (idx_r == head.last_idx);
  assign pop     = load && is_last;

  always_comb begin
    case (idx_r)
      2'd0:    sel_char = head.c0;
      2'd1:    sel_char = head.c1;
      default: sel_char = head.c2;
    endcase
  end

  always_comb begin
    idx_nxt   = idx_r;
    valid_nxt = valid_r && !out_ready;
    if (load) begin
      valid_nxt = 1'b1;
      idx_nxt   = is_last ? 2'd0 : idx_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r   <= 2'd0;
      valid_r <= 1'b0;
    end else begin
      idx_r   <= idx_nxt;
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      char_r  <= sel_char;
      last_r  <= is_last;
      flush_r <= head.flush;
    end
  end

  assign out_valid   = valid_r;
  assign out_char    = char_r;
  assign last_of_run = last_r;
  assign flush_char  = flush_r;

endmodule

[src/b64e_checker.sv]
// ----------------------------------------------------------------------------
// b64e_checker: port-level checks of the base64 stream encoder
// Watches the result channel over time; bound to the top level.
// ----------------------------------------------------------------------------
module b64e_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic [6:0] out_char,
  input logic       last_of_run,
  input logic       flush_char
);
  import b64e_pkg::*;

  // Reset leaves no character pending
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid after reset");

  // Pad only comes from a flush
  a_pad_flush: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_char == PAD_CHAR) |-> flush_char)
    else $error("pad character outside a flush");

  // A pad transfer is either flush_char and not last_of_run, or last_of_run
  a_pad_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready && out_char == PAD_CHAR) |->
      (flush_char && !last_of_run) || last_of_run)
    else $error("pad with inconsistent run marks");

  // Stalled output holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=>
      (out_valid && $stable(out_char) && $stable(last_of_run)
       && $stable(flush_char)))
    else $error("stalled transfer changed");

endmodule

bind base64_stream_encoder_top b64e_checker u_b64e_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .out_valid   (out_m.valid),
  .out_ready   (out_m.ready),
  .out_char    (out_m.out_char),
  .last_of_run (out_m.last_of_run),
  .flush_char  (out_m.flush_char)
);

[bench/base64_stream_encoder_top_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// base64_stream_encoder_top_tb: self-checking bench of the base64 encoder
// Streams messages of bytes closed by end-of-message items into the encoder,
// predicts every character, pad, last and flush flag in step with each input
// transfer, and checks each output transfer against the oldest prediction
// with random idling and stalls on both channels outside the full-rate test.
// ----------------------------------------------------------------------------
module base64_stream_encoder_top_tb;
  import b64e_pkg::*;

  localparam int CLK_HALF       = 10;    // 20 ns period
  localparam int RESET_CYCLES   = 4;
  localparam int WATCHDOG_LIMIT = 2000;  // cycles without any transfer
  localparam int DRAIN_CYCLES   = 20;
  localparam int RANDOM_ITEMS   = 300;
  localparam int TAIL_ITEMS     = 60;

  // One predicted character on the output channel
  typedef struct packed {
    logic [6:0] ch;
    logic       last;
    logic       flush;
  } char_exp_t;

  logic clk = 1'b0;
  logic rst_n;

  b64e_in_if  in_ch ();
  b64e_out_if out_ch ();

  base64_stream_encoder_top DUT (
    .clk   (clk),
    .rst_n (rst_n),
    .in_s  (in_ch),
    .out_m (out_ch)
  );

  // Predictor state: position in the 3-byte group and the byte before it
  logic [1:0] enc_phase;
  logic [7:0] enc_prev;

  // Characters predicted but not yet seen on the output, oldest first
  char_exp_t  pending_chars[$];

  string b64_alphabet =
    "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

  int  mismatch_count = 0;
  int  items_sent     = 0;
  int  idle_cycles    = 0;
  bit  idle_en        = 1'b1;  // random idling on both channels

  // --------------------------------------------------------------------------
  // Clock
  // --------------------------------------------------------------------------
  always begin
    #CLK_HALF clk = 1'b1;
    #CLK_HALF clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Predictor
  // --------------------------------------------------------------------------
  function automatic logic [6:0] b64_char(input logic [5:0] six);
    return 7'(b64_alphabet[six]);
  endfunction

  function automatic void push_char(input logic [6:0] ch, input logic last,
                                    input logic flush);
    char_exp_t e;
    e.ch    = ch;
    e.last  = last;
    e.flush = flush;
    pending_chars.push_back(e);
  endfunction

  // Advance the group state by one accepted item and queue its characters.
  // A byte completes one character, two on the third byte of a group; an
  // end-of-message item pushes out the leftover bits and pads to four.
  function automatic void encode_item(input logic op, input logic [7:0] b);
    if (op == OP_DATA) begin
      case (enc_phase)
        PH_1: begin
          push_char(b64_char({enc_prev[1:0], b[7:4]}), 1'b1, 1'b0);
          enc_phase = PH_2;
        end
        PH_2: begin
          push_char(b64_char({enc_prev[3:0], b[7:6]}), 1'b0, 1'b0);
          push_char(b64_char(b[5:0]), 1'b1, 1'b0);
          enc_phase = PH_0;
        end
        default: begin
          // the phase that never arises behaves like the start of a group
          push_char(b64_char(b[7:2]), 1'b1, 1'b0);
          enc_phase = PH_1;
        end
      endcase
      enc_prev = b;
    end else begin
      case (enc_phase)
        PH_1: begin
          push_char(b64_char({enc_prev[1:0], 4'b0000}), 1'b0, 1'b1);
          push_char(PAD_CHAR, 1'b0, 1'b1);
          push_char(PAD_CHAR, 1'b1, 1'b1);
        end
        PH_2: begin
          push_char(b64_char({enc_prev[3:0], 2'b00}), 1'b0, 1'b1);
          push_char(PAD_CHAR, 1'b1, 1'b1);
        end
        default: ;  // nothing left over, nothing emitted
      endcase
      enc_phase = PH_0;
    end
  endfunction

  // --------------------------------------------------------------------------
  // Input driver: entered and left at a falling edge. Drop valid for a random
  // burst now and then, present the item, hold it until the transfer.
  // --------------------------------------------------------------------------
  task automatic send_item(input logic op, input logic [7:0] b);
    int gap;
    if (idle_en && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 16);
      in_ch.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid     = 1'b1;
    in_ch.op        = op;
    in_ch.data_byte = b;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    // transfer happened at this edge: predict what it causes
    encode_item(op, b);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic send_byte(input logic [7:0] b);
    send_item(OP_DATA, b);
  endtask

  // End of message; data_byte carries junk that must be ignored
  task automatic send_flush();
    send_item(OP_FLUSH, 8'($urandom_range(0, 255)));
  endtask

  // Mostly uniform bytes, with the all-zero and all-one extremes mixed in
  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 7))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Output stall driver: hold ready for random bursts, each high with odds
  // of two in three; hold ready high whenever idling is switched off.
  // --------------------------------------------------------------------------
  initial begin
    int  hold_left;
    hold_left    = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (!idle_en) begin
        out_ch.ready = 1'b1;
        hold_left    = 0;
      end else if (hold_left > 0) begin
        hold_left--;
      end else begin
        out_ch.ready = ($urandom_range(0, 2) != 0);
        hold_left    = $urandom_range(1, 16) - 1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Result checker: compare each output transfer with the oldest prediction
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    char_exp_t exp_c;
    if (rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      if (pending_chars.size() == 0) begin
        $error("unexpected character: out_char=%h last_of_run=%b flush_char=%b",
               out_ch.out_char, out_ch.last_of_run, out_ch.flush_char);
        mismatch_count++;
      end else begin
        exp_c = pending_chars.pop_front();
        if (out_ch.out_char !== exp_c.ch) begin
          $error("out_char: expected %h, actual %h", exp_c.ch, out_ch.out_char);
          mismatch_count++;
        end
        if (out_ch.last_of_run !== exp_c.last) begin
          $error("last_of_run: expected %b, actual %b",
                 exp_c.last, out_ch.last_of_run);
          mismatch_count++;
        end
        if (out_ch.flush_char !== exp_c.flush) begin
          $error("flush_char: expected %b, actual %b",
                 exp_c.flush, out_ch.flush_char);
          mismatch_count++;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Watchdog: end the run once no transfer has happened for too long
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if ((in_ch.valid === 1'b1 && in_ch.ready === 1'b1) ||
        (out_ch.valid === 1'b1 && out_ch.ready === 1'b1)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Short known messages: every flush case, field extremes, and the last two
  // alphabet entries
  task automatic test_directed();
    send_flush();                              // flush right after reset
    send_byte(8'h00); send_flush();            // one byte left over
    send_byte(8'hFF); send_flush();
    send_byte(8'hFF); send_byte(8'hFF);        // two bytes left over
    send_flush();
    send_byte(8'h4D); send_byte(8'h61);        // full group, then empty flush
    send_byte(8'h6E); send_flush();
    send_byte(8'hFB); send_byte(8'hEF);        // all '+'
    send_byte(8'hBE);
    send_byte(8'hFF); send_byte(8'hFF);        // all '/'
    send_byte(8'hFF);
    send_flush(); send_flush();                // back-to-back flushes
  endtask

  // Random messages: mostly well-formed byte runs closed by a flush, plus
  // stray flushes and runs that carry on into the next message
  task automatic test_random_messages(input int n_items);
    int start;
    int len;
    int kind;
    start = items_sent;
    while (items_sent - start < n_items) begin
      kind = $urandom_range(0, 9);
      if (kind == 0) begin
        send_flush();
      end else begin
        len = ($urandom_range(0, 5) == 0) ? 0 : $urandom_range(1, 12);
        repeat (len) send_byte(pick_byte());
        if (kind != 1) send_flush();
      end
    end
  endtask

  // Back-to-back traffic at full rate with no input idling and ready held high
  task automatic test_full_rate(input int n_items);
    idle_en = 1'b0;
    test_random_messages(n_items);
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    rst_n           = 1'b0;
    in_ch.valid     = 1'b0;
    in_ch.op        = OP_DATA;
    in_ch.data_byte = 8'h00;
    enc_phase       = PH_0;
    enc_prev        = 8'h00;
    repeat (RESET_CYCLES) @(negedge clk);
    rst_n = 1'b1;

    test_directed();
    test_random_messages(RANDOM_ITEMS);
    test_full_rate(TAIL_ITEMS);
    in_ch.valid = 1'b0;

    // wait for every predicted character, then let the pipe settle
    while (pending_chars.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatch_count == 0 && pending_chars.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
